// ===== sv/stdsu_pkg.sv =====
package stdsu_pkg;

   localparam int TagWidth   = 8;
   localparam int ScoreWidth = 31;
   localparam int DataWidth  = 40;   // tag + score, padded to whole bytes

   // one queued entry from the front end
   typedef struct packed {
      logic [TagWidth-1:0]   tag;
      logic [ScoreWidth-1:0] score;
      logic                  last;
   } entry_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

// ===== sv/stdsu_front.sv =====
module stdsu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [stdsu_pkg::DataWidth-1:0] req_tdata,
   input  logic                 req_tlast,
   output logic                 q_valid,
   input  logic                 q_ready,
   output stdsu_pkg::entry_type q_entry
);
   import stdsu_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   entry_type  in_entry;

   // unpack the incoming item
   assign in_entry.tag   = req_tdata[TagWidth-1:0];
   assign in_entry.score = req_tdata[TagWidth+ScoreWidth-1:TagWidth];
   assign in_entry.last  = req_tlast;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_entry    = slot_ff[rd_ptr_ff];

   // two-entry queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_entry;
   end

endmodule

// ===== sv/stdsu_back.sv =====
module stdsu_back #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  stdsu_pkg::entry_type q_entry,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [stdsu_pkg::DataWidth-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);
   import stdsu_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [ScoreWidth-1:0] score_ff [MAX_ENTRIES];
   logic [ScoreWidth-1:0] score_in [MAX_ENTRIES];
   logic [TagWidth-1:0]   tag_ff   [MAX_ENTRIES];
   logic [TagWidth-1:0]   tag_in   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid, gt, shift;
   logic                  pop, store, rsp_fire, full;

   assign q_ready  = (state_ff == ST_LOAD);
   assign pop      = q_valid && q_ready;
   assign full     = (count_ff == CW'(MAX_ENTRIES));
   assign store    = pop && !full;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // per-cell compare against the entry being inserted
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid[i] = (CW'(i) < count_ff);
         gt[i]    = (q_entry.score > score_ff[i]);
         shift[i] = valid[i] && gt[i];
      end
   end

   // insertion chain while loading, shift toward cell 0 while emitting
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic from_prev, from_next;
      if (g == 0) begin : g_head
         assign from_prev = 1'b0;
      end else begin : g_body
         assign from_prev = shift[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_tail
         assign from_next = 1'b0;
      end else begin : g_inner
         assign from_next = 1'b1;
      end

      always_comb begin
         score_in[g] = score_ff[g];
         tag_in[g]   = tag_ff[g];
         if (store) begin
            if (from_prev) begin
               score_in[g] = score_ff[(g == 0) ? 0 : g-1];
               tag_in[g]   = tag_ff[(g == 0) ? 0 : g-1];
            end else if (!valid[g] || gt[g]) begin
               score_in[g] = q_entry.score;
               tag_in[g]   = q_entry.tag;
            end
         end else if (rsp_fire && from_next) begin
            score_in[g] = score_ff[(g == MAX_ENTRIES - 1) ? g : g+1];
            tag_in[g]   = tag_ff[(g == MAX_ENTRIES - 1) ? g : g+1];
         end
      end

      always_ff @(posedge clock) begin
         score_ff[g] <= score_in[g];
         tag_ff[g]   <= tag_in[g];
      end
   end

   // sequencer: load until last, then drain the sorted cells
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (full) dropped_in = 1'b1;
               else      count_in   = count_ff + CW'(1);
               if (q_entry.last) state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // result comes straight from the head cell
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {{(DataWidth-TagWidth-ScoreWidth){1'b0}}, score_ff[0], tag_ff[0]};
   assign rsp_tlast  = (count_ff == CW'(1));
   assign rsp_tuser  = dropped_ff;

endmodule

// ===== sv/score_table_descending_sort_unit.sv =====
// Descending score sort. Entries (tag, score) stream in one item per cycle
// while req_tready is high and pass through a two-entry queue into an
// insertion chain of MAX_ENTRIES cells, which keeps them in descending
// score order as they arrive (equal scores keep arrival order). The item
// with tlast closes the set; the sorted entries then leave one per cycle
// from the head cell while rsp_tready is high, tlast on the lowest-ranked
// one and tuser set on every result if entries past capacity were dropped.
// Each item is placed by a parallel compare across all cells; loading of
// the next set resumes the cycle after the last result is taken, with the
// queue holding up to two items meanwhile.
module score_table_descending_sort_unit #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [stdsu_pkg::DataWidth-1:0] req_tdata,  // player_tag, score, zero pad
   input  logic        req_tlast,                      // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [stdsu_pkg::DataWidth-1:0] rsp_tdata,  // out_tag, out_score, zero pad
   output logic        rsp_tlast,                      // out_last
   output logic        rsp_tuser                       // overflow
);
   import stdsu_pkg::*;

   entry_type q_entry;
   logic      q_valid, q_ready;

   stdsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry)
   );

   stdsu_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/stdsu_checker.sv =====
module stdsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [stdsu_pkg::DataWidth-1:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   import stdsu_pkg::*;

   logic rsp_fire;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // scores never rise within a burst
   a_desc: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tvalid &&
      (rsp_tdata[TagWidth+ScoreWidth-1:TagWidth] <=
       $past(rsp_tdata[TagWidth+ScoreWidth-1:TagWidth])))
      else $error("burst not in descending order");

   // overflow flag is the same on every result of a burst
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tlast |=> rsp_tuser == $past(rsp_tuser))
      else $error("overflow flag changed within a burst");

   // a burst ends cleanly, the next one needs a new set
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> !rsp_tvalid)
      else $error("result right after end of burst");

endmodule

bind score_table_descending_sort_unit stdsu_checker u_stdsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
